FILE: sv/ple_pkg.sv
package ple_pkg;

	localparam int POS_BITS       = 9;
	localparam int WORD_IN_BITS   = 32;
	localparam int FOUND_BITS     = 8;
	localparam int COUNT_OUT_BITS = 9;

	typedef enum logic [2:0] {
		ACT_READ       = 3'd0,
		ACT_WRITE      = 3'd1,
		ACT_INSERT     = 3'd2,
		ACT_REMOVE     = 3'd3,
		ACT_FIND_FIRST = 3'd4,
		ACT_FIND_LAST  = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		action_t                         action;
		logic [POS_BITS-1:0]             position;
		logic signed [WORD_IN_BITS-1:0]  word_in;
	} req_t;

	typedef struct packed {
		logic signed [WORD_IN_BITS-1:0]  word_out;
		logic [FOUND_BITS-1:0]           found_position;
		status_t                         status;
		logic [COUNT_OUT_BITS-1:0]       entry_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RMW_WAIT,
		S_INS_SHIFT,
		S_INS_PUT,
		S_REM_SHIFT,
		S_FIND_SCAN,
		S_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    capture;     // register the incoming request
		logic    issue_rmw;   // read the word at the request position
		logic    ptr_init;    // load the scan pointer for the held action
		logic    step;        // issue one element of the shift or scan
		logic    put_word;    // write the request word at the request position
		logic    note_hit;    // record the compared address as the match
		logic    set_status;
		status_t status;
		logic    finish;      // load the response register, commit count
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		action_t act;
		logic    range_bad;
		logic    full;
		logic    step_left;
		logic    hit;
		logic    cmp_pending;
		logic    out_free;
	} stat_t;

endpackage

FILE: sv/ple_ctrl.sv
module ple_ctrl import ple_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	output logic   req_stall,
	input  stat_t  stat,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.status = ST_OK;
		state_d    = state_q;
		req_stall  = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.set_status = 1'b1;
				case (stat.act)
					ACT_READ, ACT_WRITE: begin
						if (stat.range_bad) begin
							cmd.status = ST_RANGE;
							state_d    = S_FINISH;
						end else begin
							cmd.issue_rmw = 1'b1;
							state_d       = S_RMW_WAIT;
						end
					end
					ACT_REMOVE: begin
						if (stat.range_bad) begin
							cmd.status = ST_RANGE;
							state_d    = S_FINISH;
						end else begin
							cmd.issue_rmw = 1'b1;
							cmd.ptr_init  = 1'b1;
							state_d       = S_REM_SHIFT;
						end
					end
					ACT_INSERT: begin
						if (stat.range_bad) begin
							cmd.status = ST_RANGE;
							state_d    = S_FINISH;
						end else if (stat.full) begin
							cmd.status = ST_FULL;
							state_d    = S_FINISH;
						end else begin
							cmd.ptr_init = 1'b1;
							state_d      = S_INS_SHIFT;
						end
					end
					ACT_FIND_FIRST, ACT_FIND_LAST: begin
						cmd.ptr_init = 1'b1;
						state_d      = S_FIND_SCAN;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_RMW_WAIT: begin
				if (stat.act == ACT_WRITE) begin
					cmd.put_word = 1'b1;
				end
				state_d = S_FINISH;
			end
			S_INS_SHIFT: begin
				// last cycle issues nothing so the pending move drains
				if (stat.step_left) begin
					cmd.step = 1'b1;
				end else begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT: begin
				cmd.put_word = 1'b1;
				state_d      = S_FINISH;
			end
			S_REM_SHIFT: begin
				if (stat.step_left) begin
					cmd.step = 1'b1;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FIND_SCAN: begin
				if (stat.hit) begin
					cmd.note_hit = 1'b1;
					state_d      = S_FINISH;
				end else if (stat.step_left) begin
					cmd.step = 1'b1;
				end else if (!stat.cmp_pending) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NOT_FOUND;
					state_d        = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/ple_datapath.sv
module ple_datapath import ple_pkg::*; #(
	parameter int DEPTH     = 256,
	parameter int WORD_BITS = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	input  req_t   req,
	input  cmd_t   cmd,
	output stat_t  stat,
	output logic   rsp_valid,
	input  logic   rsp_stall,
	output rsp_t   rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > POS_BITS) ? CW : POS_BITS;
	localparam int OB = (WORD_BITS < WORD_IN_BITS) ? WORD_BITS : WORD_IN_BITS;
	localparam int FB = (AW < FOUND_BITS) ? AW : FOUND_BITS;
	localparam int CB = (CW < COUNT_OUT_BITS) ? CW : COUNT_OUT_BITS;

	logic [WORD_BITS-1:0]    mem [DEPTH];

	action_t                 act_q;
	logic [POS_BITS-1:0]     pos_q;
	logic [WORD_BITS-1:0]    word_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           ptr_q;
	logic [WORD_BITS-1:0]    rd_data_q;
	logic                    wb_valid_q;
	logic [AW-1:0]           wb_addr_q;
	logic                    cap_q;
	logic                    cmp_valid_q;
	logic [AW-1:0]           cmp_addr_q;
	logic [WORD_BITS-1:0]    word_res_q;
	logic [AW-1:0]           found_q;
	status_t                 status_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic [2*WORD_IN_BITS-1:0] word_sx;
	logic [LW-1:0]           pos_l;
	logic [LW-1:0]           count_l;
	logic [CW-1:0]           pos_c;
	logic [CW-1:0]           ptr_m1;
	logic [CW-1:0]           count_nxt;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [WORD_BITS-1:0]    wr_data;
	logic                    is_rw_word;
	logic                    is_find;
	logic                    out_free;
	logic [WORD_IN_BITS-1:0] word_ext;
	logic [FOUND_BITS-1:0]   found_ext;
	logic [COUNT_OUT_BITS-1:0] count_ext;

	assign word_sx = {{WORD_IN_BITS{req.word_in[WORD_IN_BITS-1]}}, req.word_in};
	assign pos_l   = LW'(pos_q);
	assign count_l = LW'(count_q);
	assign pos_c   = pos_l[CW-1:0];
	assign ptr_m1  = ptr_q - 1'b1;
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign is_rw_word = (act_q == ACT_READ) || (act_q == ACT_WRITE) || (act_q == ACT_REMOVE);
	assign is_find    = (act_q == ACT_FIND_FIRST) || (act_q == ACT_FIND_LAST);

	// status toward the controller
	always_comb begin
		stat             = '0;
		stat.act         = act_q;
		stat.full        = (count_q == CW'(DEPTH));
		stat.hit         = cmp_valid_q && (rd_data_q == word_q);
		stat.cmp_pending = cmp_valid_q;
		stat.out_free    = out_free;
		case (act_q)
			ACT_INSERT: begin
				stat.range_bad = (pos_l > count_l);
				stat.step_left = (ptr_q > pos_c);
			end
			ACT_READ, ACT_WRITE: begin
				stat.range_bad = (pos_l >= count_l);
			end
			ACT_REMOVE: begin
				stat.range_bad = (pos_l >= count_l);
				stat.step_left = (ptr_q < count_q);
			end
			ACT_FIND_FIRST: begin
				stat.step_left = (ptr_q < count_q);
			end
			ACT_FIND_LAST: begin
				stat.step_left = (ptr_q != '0);
			end
			default: begin
				stat.range_bad = 1'b0;
			end
		endcase
	end

	// read address: walking down for insert and find-last, up otherwise
	always_comb begin
		rd_addr = pos_c[AW-1:0];
		if (cmd.step) begin
			if ((act_q == ACT_INSERT) || (act_q == ACT_FIND_LAST)) begin
				rd_addr = ptr_m1[AW-1:0];
			end else begin
				rd_addr = ptr_q[AW-1:0];
			end
		end
	end

	assign wr_en   = wb_valid_q || cmd.put_word;
	assign wr_addr = cmd.put_word ? pos_c[AW-1:0] : wb_addr_q;
	assign wr_data = cmd.put_word ? word_q : rd_data_q;

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (status_q == ST_OK) begin
			if (act_q == ACT_INSERT) begin
				count_nxt = count_q + 1'b1;
			end else if (act_q == ACT_REMOVE) begin
				count_nxt = count_q - 1'b1;
			end
		end
	end

	always_comb begin
		word_ext  = '0;
		found_ext = '0;
		count_ext = '0;
		if ((status_q == ST_OK) && is_rw_word) begin
			word_ext[OB-1:0] = word_res_q[OB-1:0];
		end
		if ((status_q == ST_OK) && is_find) begin
			found_ext[FB-1:0] = found_q[FB-1:0];
		end
		count_ext[CB-1:0] = count_nxt[CB-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= req.action;
			pos_q  <= req.position;
			word_q <= word_sx[WORD_BITS-1:0];
		end
		if (cmd.ptr_init) begin
			case (act_q)
				ACT_INSERT, ACT_FIND_LAST: ptr_q <= count_q;
				ACT_REMOVE:                ptr_q <= pos_c + 1'b1;
				default:                   ptr_q <= '0;
			endcase
		end else if (cmd.step) begin
			if ((act_q == ACT_INSERT) || (act_q == ACT_FIND_LAST)) begin
				ptr_q <= ptr_m1;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
		wb_addr_q  <= (act_q == ACT_INSERT) ? ptr_q[AW-1:0] : ptr_m1[AW-1:0];
		cmp_addr_q <= (act_q == ACT_FIND_FIRST) ? ptr_q[AW-1:0] : ptr_m1[AW-1:0];
		if (cap_q) begin
			word_res_q <= rd_data_q;
		end
		if (cmd.note_hit) begin
			found_q <= cmp_addr_q;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.finish) begin
			rsp_q.word_out       <= word_ext;
			rsp_q.found_position <= found_ext;
			rsp_q.status         <= status_q;
			rsp_q.entry_count    <= count_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			wb_valid_q  <= 1'b0;
			cap_q       <= 1'b0;
			cmp_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			wb_valid_q  <= cmd.step && ((act_q == ACT_INSERT) || (act_q == ACT_REMOVE));
			cmp_valid_q <= cmd.step && is_find;
			cap_q       <= cmd.issue_rmw;
			if (cmd.finish) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_wr_port_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(wb_valid_q && cmd.put_word))
		else $error("shift write-back and word write in the same cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_hit_has_compare: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.note_hit |-> cmp_valid_q)
		else $error("match recorded without a compare in flight");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !cmd.finish)
		else $error("response overwritten while stalled");

endmodule

FILE: sv/positional_list_engine.sv
// Indexed list of up to DEPTH signed words, one request transaction at a time.
// Request channel (req_valid / req_stall / req): action, position, word_in.
//   Read, write (returns old word), insert at 0..count, remove (returns the
//   word), find first and find last match of word_in.
// Response channel (rsp_valid / rsp_stall / rsp): one transaction per
//   request with word_out, found_position, status and entry_count after it.
// A find stops scanning as soon as a match is seen.
// The store is a single-port-write, registered-read RAM; every shift or scan
// moves one word per cycle, which sets the rate. The next request is taken
// in the cycle after the response is loaded into the output register.
// Reset empties the list (count to zero); the RAM itself is not cleared.
// When the receiver stalls, the response holds in the output register; the
// block still accepts and works on the next request and waits only when it
// has a second response to load.
module positional_list_engine import ple_pkg::*; #(
	parameter int DEPTH     = 256,
	parameter int WORD_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,

	input  logic  req_valid,
	output logic  req_stall,
	input  req_t  req,

	output logic  rsp_valid,
	input  logic  rsp_stall,
	output rsp_t  rsp
);

	cmd_t  cmd;   // sequencing commands
	stat_t stat;  // range, scan and output-register status

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// RAM, scan pointer, compare and response register
	ple_datapath #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
